FILE: rtl/fso_pkg.sv
// ----------------------------------------------------------------------------
// fso_pkg
// Shared types, constants, coefficient tables and sequencer tables of the
// fractal spiral oscillator.
// ----------------------------------------------------------------------------
package fso_pkg;

  localparam int MAX_OCTAVES = 16;
  localparam int OCT_LEN     = 44;
  localparam int POST_LEN    = 74;
  localparam int DIV_BITS    = 31;

  // datapath operation codes
  localparam logic [5:0] OP_NOP      = 6'd0;
  localparam logic [5:0] OP_START    = 6'd1;
  localparam logic [5:0] OP_MUL_MHP  = 6'd2;
  localparam logic [5:0] OP_MUL_MLP  = 6'd3;
  localparam logic [5:0] OP_MUL_UU   = 6'd4;
  localparam logic [5:0] OP_MUL_TU2  = 6'd5;
  localparam logic [5:0] OP_MUL_UT   = 6'd6;
  localparam logic [5:0] OP_MUL_WT   = 6'd7;
  localparam logic [5:0] OP_MUL_WG   = 6'd8;
  localparam logic [5:0] OP_MUL_MHL  = 6'd9;
  localparam logic [5:0] OP_MUL_MLL  = 6'd10;
  localparam logic [5:0] OP_MUL_GD   = 6'd11;
  localparam logic [5:0] OP_MUL_XL   = 6'd12;
  localparam logic [5:0] OP_MUL_FL   = 6'd13;
  localparam logic [5:0] OP_MUL_EY   = 6'd14;
  localparam logic [5:0] OP_MUL_EHS  = 6'd15;
  localparam logic [5:0] OP_MUL_ELS  = 6'd16;
  localparam logic [5:0] OP_MUL_NXCS = 6'd17;
  localparam logic [5:0] OP_MUL_NYSN = 6'd18;
  localparam logic [5:0] OP_MUL_NXSN = 6'd19;
  localparam logic [5:0] OP_MUL_NYCS = 6'd20;
  localparam logic [5:0] OP_MUL_RXH  = 6'd21;
  localparam logic [5:0] OP_MUL_RXL  = 6'd22;
  localparam logic [5:0] OP_MUL_RYH  = 6'd23;
  localparam logic [5:0] OP_MUL_RYL  = 6'd24;
  localparam logic [5:0] OP_WB_SH0   = 6'd25;
  localparam logic [5:0] OP_WB_SH16  = 6'd26;
  localparam logic [5:0] OP_WB_SH18  = 6'd27;
  localparam logic [5:0] OP_WB_SH24  = 6'd28;
  localparam logic [5:0] OP_WB_ANG   = 6'd29;
  localparam logic [5:0] OP_TRIG_SET = 6'd30;
  localparam logic [5:0] OP_WB_U2    = 6'd31;
  localparam logic [5:0] OP_WB_H     = 6'd32;
  localparam logic [5:0] OP_WB_TRIG  = 6'd33;
  localparam logic [5:0] OP_WB_SX    = 6'd34;
  localparam logic [5:0] OP_WB_SY    = 6'd35;
  localparam logic [5:0] OP_WB_W     = 6'd36;
  localparam logic [5:0] OP_WB_M     = 6'd37;
  localparam logic [5:0] OP_WB_X     = 6'd38;
  localparam logic [5:0] OP_WB_T     = 6'd39;
  localparam logic [5:0] OP_WB_Y     = 6'd40;
  localparam logic [5:0] OP_WB_E     = 6'd41;
  localparam logic [5:0] OP_WB_ENV   = 6'd42;
  localparam logic [5:0] OP_WB_RAD   = 6'd43;
  localparam logic [5:0] OP_SET_SPC  = 6'd44;
  localparam logic [5:0] OP_SAVE_CS  = 6'd45;
  localparam logic [5:0] OP_SAVE_SN  = 6'd46;
  localparam logic [5:0] OP_WB_RX    = 6'd47;
  localparam logic [5:0] OP_WB_RY    = 6'd48;
  localparam logic [5:0] OP_WB_OX    = 6'd49;
  localparam logic [5:0] OP_WB_OY    = 6'd50;
  localparam logic [5:0] OP_DIV_LOAD = 6'd51;
  localparam logic [5:0] OP_DIV_STEP = 6'd52;
  localparam logic [5:0] OP_DIV_STORE = 6'd53;
  localparam logic [5:0] OP_LOAD_OUT = 6'd54;

  // configuration register indexes
  localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [2:0] REG_SPIN_STEP     = 3'd1;
  localparam logic [2:0] REG_RADIUS_SCALE  = 3'd2;
  localparam logic [2:0] REG_GROWTH_RATE   = 3'd3;
  localparam logic [2:0] REG_OCTAVE_WEIGHT = 3'd4;
  localparam logic [2:0] REG_SPEED_RATIO   = 3'd5;
  localparam logic [2:0] REG_OCTAVE_COUNT  = 3'd6;
  localparam logic [2:0] REG_TWIST_TURNS   = 3'd7;

  typedef struct packed {
    logic [5:0] op;
    logic       sel;   // 0: x channel, 1: y channel (divider)
  } cmd_t;

  typedef struct packed {
    logic [4:0] n_oct;
  } status_t;

  function automatic logic signed [31:0] sin_coef(input logic [2:0] i);
    logic signed [31:0] c;
    unique case (i)
      3'd0: c = 32'sd1686629713;
      3'd1: c = -32'sd693598668;
      3'd2: c = 32'sd85569306;
      3'd3: c = -32'sd5026995;
      3'd4: c = 32'sd172272;
      3'd5: c = -32'sd3864;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] exp_coef(input logic [2:0] i);
    logic [31:0] c;
    unique case (i)
      3'd0: c = 32'd1073741824;
      3'd1: c = 32'd1073741824;
      3'd2: c = 32'd536870912;
      3'd3: c = 32'd178956971;
      3'd4: c = 32'd44739243;
      3'd5: c = 32'd8947849;
      3'd6: c = 32'd1491308;
      3'd7: c = 32'd213044;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  // sine of the angle in ta, result in trg
  function automatic logic [5:0] trig_op(input logic [3:0] j);
    logic [5:0] o;
    unique case (j)
      4'd0: o = OP_TRIG_SET;
      4'd1: o = OP_MUL_UU;
      4'd2: o = OP_WB_U2;
      4'd3, 4'd5, 4'd7, 4'd9, 4'd11: o = OP_MUL_TU2;
      4'd4, 4'd6, 4'd8, 4'd10, 4'd12: o = OP_WB_H;
      4'd13: o = OP_MUL_UT;
      4'd14: o = OP_WB_TRIG;
      default: o = OP_NOP;
    endcase
    return o;
  endfunction

  function automatic logic [5:0] oct_op(input logic [5:0] i);
    logic [5:0] o;
    priority if (i >= 6'd4 && i <= 6'd18) o = trig_op(4'(i - 6'd4));
    else if (i >= 6'd21 && i <= 6'd35) o = trig_op(4'(i - 6'd21));
    else begin
      unique case (i)
        6'd0:  o = OP_MUL_MHP;
        6'd1:  o = OP_WB_SH24;
        6'd2:  o = OP_MUL_MLP;
        6'd3:  o = OP_WB_ANG;
        6'd19: o = OP_MUL_WT;
        6'd20: o = OP_WB_SX;
        6'd36: o = OP_MUL_WT;
        6'd37: o = OP_WB_SY;
        6'd38: o = OP_MUL_WG;
        6'd39: o = OP_WB_W;
        6'd40: o = OP_MUL_MHL;
        6'd41: o = OP_WB_SH16;
        6'd42: o = OP_MUL_MLL;
        6'd43: o = OP_WB_M;
        default: o = OP_NOP;
      endcase
    end
    return o;
  endfunction

  function automatic logic [5:0] post_op(input logic [6:0] i);
    logic [5:0] o;
    priority if (i >= 7'd6 && i <= 7'd19) o = i[0] ? OP_WB_E : OP_MUL_EY;
    else if (i >= 7'd26 && i <= 7'd40) o = trig_op(4'(i - 7'd26));
    else if (i >= 7'd42 && i <= 7'd56) o = trig_op(4'(i - 7'd42));
    else begin
      unique case (i)
        7'd0:  o = OP_MUL_GD;
        7'd1:  o = OP_WB_X;
        7'd2:  o = OP_MUL_XL;
        7'd3:  o = OP_WB_T;
        7'd4:  o = OP_MUL_FL;
        7'd5:  o = OP_WB_Y;
        7'd20: o = OP_WB_ENV;
        7'd21: o = OP_MUL_EHS;
        7'd22: o = OP_WB_SH24;
        7'd23: o = OP_MUL_ELS;
        7'd24: o = OP_WB_RAD;
        7'd25: o = OP_SET_SPC;
        7'd41: o = OP_SAVE_CS;
        7'd57: o = OP_SAVE_SN;
        7'd58: o = OP_MUL_NXCS;
        7'd59: o = OP_WB_SH0;
        7'd60: o = OP_MUL_NYSN;
        7'd61: o = OP_WB_RX;
        7'd62: o = OP_MUL_NXSN;
        7'd63: o = OP_WB_SH0;
        7'd64: o = OP_MUL_NYCS;
        7'd65: o = OP_WB_RY;
        7'd66: o = OP_MUL_RXH;
        7'd67: o = OP_WB_SH18;
        7'd68: o = OP_MUL_RXL;
        7'd69: o = OP_WB_OX;
        7'd70: o = OP_MUL_RYH;
        7'd71: o = OP_WB_SH18;
        7'd72: o = OP_MUL_RYL;
        7'd73: o = OP_WB_OY;
        default: o = OP_NOP;
      endcase
    end
    return o;
  endfunction

endpackage

FILE: rtl/fso_ctrl.sv
// ----------------------------------------------------------------------------
// fso_ctrl
// Sequencer: steps the datapath through the octave loop, the two divisions
// and the envelope / rotation tail, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module fso_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_tick,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fso_pkg::status_t stat,
  output fso_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OCT  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state, state_next;
  logic [6:0] idx, idx_next;
  logic [4:0] k, k_next;
  logic [5:0] cnt, cnt_next;
  logic       sel, sel_next;
  logic       ovalid, ovalid_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = ovalid;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    k_next      = k;
    cnt_next    = cnt;
    sel_next    = sel;
    ovalid_next = ovalid && !out_ready;
    cmd.op      = fso_pkg::OP_NOP;
    cmd.sel     = sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_tick) begin
          cmd.op     = fso_pkg::OP_START;
          state_next = ST_OCT;
          idx_next   = '0;
          k_next     = '0;
        end
      end
      ST_OCT: begin
        cmd.op = fso_pkg::oct_op(idx[5:0]);
        if (idx == 7'(fso_pkg::OCT_LEN - 1)) begin
          idx_next = '0;
          if (k == stat.n_oct - 5'd1) begin
            state_next = ST_DIV;
            cnt_next   = '0;
            sel_next   = 1'b0;
          end else begin
            k_next = k + 5'd1;
          end
        end else begin
          idx_next = idx + 7'd1;
        end
      end
      ST_DIV: begin
        priority if (cnt == '0) cmd.op = fso_pkg::OP_DIV_LOAD;
        else if (cnt == 6'(fso_pkg::DIV_BITS + 1)) cmd.op = fso_pkg::OP_DIV_STORE;
        else cmd.op = fso_pkg::OP_DIV_STEP;
        if (cnt == 6'(fso_pkg::DIV_BITS + 1)) begin
          cnt_next = '0;
          if (sel) begin
            state_next = ST_POST;
            idx_next   = '0;
          end else begin
            sel_next = 1'b1;
          end
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_POST: begin
        cmd.op = fso_pkg::post_op(idx);
        if (idx == 7'(fso_pkg::POST_LEN - 1)) state_next = ST_FIN;
        else idx_next = idx + 7'd1;
      end
      ST_FIN: begin
        // output register free or being emptied this cycle
        if (!ovalid || out_ready) begin
          cmd.op      = fso_pkg::OP_LOAD_OUT;
          ovalid_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      idx    <= '0;
      k      <= '0;
      cnt    <= '0;
      sel    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      k      <= k_next;
      cnt    <= cnt_next;
      sel    <= sel_next;
      ovalid <= ovalid_next;
    end
  end

endmodule

FILE: rtl/fso_dp.sv
// ----------------------------------------------------------------------------
// fso_dp
// Datapath: configuration and phase registers, one shared 33x33 signed
// multiplier with a product register, a radix-2 divider and the working
// registers of the octave sum, envelope and rotation.
// ----------------------------------------------------------------------------
module fso_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [31:0]      cfg_wdata,
  input  fso_pkg::cmd_t    cmd,
  output fso_pkg::status_t stat,
  output logic [24:0]      res_x,
  output logic [24:0]      res_y,
  output logic [24:0]      res_z
);

  // configuration
  logic [31:0]        phase_step, spin_step;
  logic [16:0]        radius_scale;
  logic signed [16:0] growth_rate;
  logic [15:0]        octave_weight;
  logic [19:0]        speed_ratio;
  logic [4:0]         octave_count;
  logic [16:0]        twist_turns;
  logic [31:0]        main_phase, spin_phase;

  // clamped views
  logic [15:0] gain;
  logic [19:0] lac;
  logic [16:0] size;

  // working registers
  logic [31:0]        p, sp;
  logic [63:0]        m;
  logic [24:0]        w;
  logic [28:0]        amp;
  logic signed [35:0] sx, sy;
  logic [15:0]        twacc;
  logic [31:0]        ang, ta;
  logic               q;
  logic [30:0]        u, u2;
  logic signed [31:0] t, trg;
  logic [2:0]         hidx, eidx;
  logic signed [63:0] acc;
  logic signed [65:0] preg;
  logic signed [31:0] nx, ny, cs, sn, rx, ry;
  logic signed [32:0] xv;
  logic signed [33:0] tv;
  logic [29:0]        y;
  logic [31:0]        e;
  logic [43:0]        env;
  logic [37:0]        radius;
  logic [24:0]        ox, oy;
  logic [28:0]        rem;
  logic [30:0]        dq;
  logic               dneg;

  logic signed [32:0] ma, mb;
  logic signed [31:0] d;

  function automatic logic [24:0] sat25(input logic signed [35:0] v);
    logic [24:0] r;
    priority if (v < -36'sd16777216) r = 25'h1000000;
    else if (v > 36'sd16777215) r = 25'h0FFFFFF;
    else r = v[24:0];
    return r;
  endfunction

  assign gain = (octave_weight < 16'd66) ? 16'd66 :
                (octave_weight > 16'd64225) ? 16'd64225 : octave_weight;
  assign lac  = (speed_ratio < 20'd65543) ? 20'd65543 :
                (speed_ratio > 20'd524288) ? 20'd524288 : speed_ratio;
  assign size = (radius_scale > 17'd65536) ? 17'd65536 : radius_scale;
  assign stat.n_oct = (octave_count == 5'd0) ? 5'd1 :
                      (octave_count > 5'(fso_pkg::MAX_OCTAVES)) ?
                      5'(fso_pkg::MAX_OCTAVES) : octave_count;

  // main phase relative to half a turn
  assign d = $signed({~p[31], p[30:0]});

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      fso_pkg::OP_MUL_MHP:  begin ma = $signed(33'(m[47:24])); mb = $signed(33'(p)); end
      fso_pkg::OP_MUL_MLP:  begin ma = $signed(33'(m[23:0]));  mb = $signed(33'(p)); end
      fso_pkg::OP_MUL_UU:   begin ma = $signed(33'(u));        mb = $signed(33'(u)); end
      fso_pkg::OP_MUL_TU2:  begin ma = 33'(t);                 mb = $signed(33'(u2)); end
      fso_pkg::OP_MUL_UT:   begin ma = $signed(33'(u));        mb = 33'(t); end
      fso_pkg::OP_MUL_WT:   begin ma = $signed(33'(w));        mb = 33'(trg); end
      fso_pkg::OP_MUL_WG:   begin ma = $signed(33'(w));        mb = $signed(33'(gain)); end
      fso_pkg::OP_MUL_MHL:  begin ma = $signed(33'(m[63:32])); mb = $signed(33'(lac)); end
      fso_pkg::OP_MUL_MLL:  begin ma = $signed(33'(m[31:0]));  mb = $signed(33'(lac)); end
      fso_pkg::OP_MUL_GD:   begin ma = 33'(growth_rate);       mb = 33'(d); end
      fso_pkg::OP_MUL_XL:   begin ma = xv;                     mb = 33'sd1549082005; end
      fso_pkg::OP_MUL_FL:   begin ma = $signed(33'(tv[27:0])); mb = 33'sd744261118; end
      fso_pkg::OP_MUL_EY:   begin ma = $signed(33'(e));        mb = $signed(33'(y)); end
      fso_pkg::OP_MUL_EHS:  begin ma = $signed(33'(env[43:24])); mb = $signed(33'(size)); end
      fso_pkg::OP_MUL_ELS:  begin ma = $signed(33'(env[23:0])); mb = $signed(33'(size)); end
      fso_pkg::OP_MUL_NXCS: begin ma = 33'(nx); mb = 33'(cs); end
      fso_pkg::OP_MUL_NYSN: begin ma = 33'(ny); mb = 33'(sn); end
      fso_pkg::OP_MUL_NXSN: begin ma = 33'(nx); mb = 33'(sn); end
      fso_pkg::OP_MUL_NYCS: begin ma = 33'(ny); mb = 33'(cs); end
      fso_pkg::OP_MUL_RXH:  begin ma = 33'(rx); mb = $signed(33'(radius[37:18])); end
      fso_pkg::OP_MUL_RXL:  begin ma = 33'(rx); mb = $signed(33'(radius[17:0])); end
      fso_pkg::OP_MUL_RYH:  begin ma = 33'(ry); mb = $signed(33'(radius[37:18])); end
      fso_pkg::OP_MUL_RYL:  begin ma = 33'(ry); mb = $signed(33'(radius[17:0])); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // configuration and phase accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= 32'd89478;
      spin_step     <= 32'd4474;
      radius_scale  <= 17'd32768;
      growth_rate   <= 17'sd6144;
      octave_weight <= 16'd32768;
      speed_ratio   <= 20'd131072;
      octave_count  <= 5'd5;
      twist_turns   <= 17'd25033;
      main_phase    <= '0;
      spin_phase    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          fso_pkg::REG_PHASE_STEP:    phase_step    <= cfg_wdata;
          fso_pkg::REG_SPIN_STEP:     spin_step     <= cfg_wdata;
          fso_pkg::REG_RADIUS_SCALE:  radius_scale  <= cfg_wdata[16:0];
          fso_pkg::REG_GROWTH_RATE:   growth_rate   <= $signed(cfg_wdata[16:0]);
          fso_pkg::REG_OCTAVE_WEIGHT: octave_weight <= cfg_wdata[15:0];
          fso_pkg::REG_SPEED_RATIO:   speed_ratio   <= cfg_wdata[19:0];
          fso_pkg::REG_OCTAVE_COUNT:  octave_count  <= cfg_wdata[4:0];
          fso_pkg::REG_TWIST_TURNS:   twist_turns   <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      if (cmd.op == fso_pkg::OP_START) begin
        main_phase <= main_phase + phase_step;
        spin_phase <= spin_phase + spin_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [47:0]        sum48;
    logic signed [35:0] v36;
    logic [30:0]        mag31;
    logic signed [35:0] s36;
    logic [34:0]        mag35;
    logic [30:0]        diff;
    logic signed [63:0] s64;
    logic [31:0]        qv;
    logic signed [5:0]  nsh;

    preg <= ma * mb;
    unique case (cmd.op)
      fso_pkg::OP_START: begin
        p     <= main_phase;
        sp    <= spin_phase;
        m     <= 64'd65536;
        w     <= 25'd16777216;
        amp   <= '0;
        sx    <= '0;
        sy    <= '0;
        twacc <= '0;
      end
      fso_pkg::OP_WB_SH0:  acc <= $signed(preg[63:0]);
      fso_pkg::OP_WB_SH16: acc <= $signed({preg[47:0], 16'd0});
      fso_pkg::OP_WB_SH18: acc <= $signed({preg[45:0], 18'd0});
      fso_pkg::OP_WB_SH24: acc <= $signed({preg[39:0], 24'd0});
      fso_pkg::OP_WB_ANG: begin
        sum48 = acc[47:0] + preg[47:0];
        ang <= sum48[47:16] + {twacc, 16'd0};
        ta  <= sum48[47:16] + {twacc, 16'd0} + 32'h4000_0000;
      end
      fso_pkg::OP_TRIG_SET: begin
        // lower half-turn bit folds the angle, upper bit gives the sign
        q <= ta[31];
        u <= ta[30] ? (31'h4000_0000 - 31'(ta[29:0])) : 31'(ta[29:0]);
      end
      fso_pkg::OP_WB_U2: begin
        u2   <= preg[60:30];
        t    <= fso_pkg::sin_coef(3'd5);
        hidx <= 3'd4;
      end
      fso_pkg::OP_WB_H: begin
        t    <= fso_pkg::sin_coef(hidx) + $signed(preg[61:30]);
        hidx <= hidx - 3'd1;
      end
      fso_pkg::OP_WB_TRIG: begin
        v36 = $signed(preg[65:30]);
        priority if (v36 < 36'sd0) mag31 = '0;
        else if (v36 > 36'sd1073741824) mag31 = 31'h4000_0000;
        else mag31 = v36[30:0];
        trg <= q ? -$signed(32'(mag31)) : $signed(32'(mag31));
      end
      fso_pkg::OP_WB_SX: begin
        sx <= sx + $signed(preg[59:24]);
        ta <= ang;
      end
      fso_pkg::OP_WB_SY: begin
        sy    <= sy + $signed(preg[59:24]);
        amp   <= amp + 29'(w);
        twacc <= twacc + twist_turns[15:0];
      end
      fso_pkg::OP_WB_W: w <= preg[40:16];
      fso_pkg::OP_WB_M: m <= acc + 64'(preg[63:16]);
      fso_pkg::OP_DIV_LOAD: begin
        s36   = cmd.sel ? sy : sx;
        mag35 = s36[35] ? 35'(-s36) : 35'(s36);
        dneg <= s36[35];
        rem  <= {1'b0, mag35[34:7]};
        dq   <= {mag35[6:0], 24'd0};
      end
      fso_pkg::OP_DIV_STEP: begin
        diff = {1'b0, rem, dq[30]} - {2'b00, amp};
        if (!diff[30]) begin
          rem <= diff[28:0];
          dq  <= {dq[29:0], 1'b1};
        end else begin
          rem <= {rem[27:0], dq[30]};
          dq  <= {dq[29:0], 1'b0};
        end
      end
      fso_pkg::OP_DIV_STORE: begin
        qv = {1'b0, dq};
        if (cmd.sel) ny <= dneg ? -$signed(qv) : $signed(qv);
        else nx <= dneg ? -$signed(qv) : $signed(qv);
      end
      fso_pkg::OP_WB_X: xv <= $signed(preg[48:16]);
      fso_pkg::OP_WB_T: tv <= $signed(preg[63:30]);
      fso_pkg::OP_WB_Y: begin
        y    <= preg[57:28];
        e    <= fso_pkg::exp_coef(3'd7);
        eidx <= 3'd6;
      end
      fso_pkg::OP_WB_E: begin
        e    <= fso_pkg::exp_coef(eidx) + preg[61:30];
        eidx <= eidx - 3'd1;
      end
      fso_pkg::OP_WB_ENV: begin
        // integer part of the base-2 exponent
        nsh = tv[33:28];
        if (!nsh[5]) env <= 44'(e) << nsh[4:0];
        else env <= 44'(e) >> 6'(-nsh);
      end
      fso_pkg::OP_WB_RAD: begin
        s64 = acc + $signed(preg[63:0]);
        radius <= s64[59:22];
      end
      fso_pkg::OP_SET_SPC: ta <= sp + 32'h4000_0000;
      fso_pkg::OP_SAVE_CS: begin
        cs <= trg;
        ta <= sp;
      end
      fso_pkg::OP_SAVE_SN: sn <= trg;
      fso_pkg::OP_WB_RX: begin
        s64 = acc - $signed(preg[63:0]);
        rx <= $signed(32'($signed(s64[63:38])));
      end
      fso_pkg::OP_WB_RY: begin
        s64 = acc + $signed(preg[63:0]);
        ry <= $signed(32'($signed(s64[63:38])));
      end
      fso_pkg::OP_WB_OX: begin
        s64 = acc + $signed(preg[63:0]);
        ox <= sat25($signed(36'($signed(s64[63:30]))));
      end
      fso_pkg::OP_WB_OY: begin
        s64 = acc + $signed(preg[63:0]);
        oy <= sat25($signed(36'($signed(s64[63:30]))));
      end
      fso_pkg::OP_LOAD_OUT: begin
        res_x <= ox;
        res_y <= oy;
        res_z <= sat25($signed({6'd0, env[43:14]}) - 36'sd65536);
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/fractal_spiral_oscillator.sv
// ----------------------------------------------------------------------------
// fractal_spiral_oscillator
// Fixed-point fractal spiral oscillator: one X/Y/Z sample per tick.
// ----------------------------------------------------------------------------
// A tick item (tdata bit 0 set) produces one sample and advances both phases;
// an item with the bit clear is taken and ignored. The octave loop runs once
// for each octave of the clamped octave count; every product goes through one
// shared 33x33 multiplier and is written back from its product register before
// the next is issued, and each normalizing division runs one quotient bit per
// cycle.
// Only one sample is in work at a time; the next item is taken while a
// finished sample waits in the output register. Configuration writes are
// accepted in every cycle and must only be issued while the block is idle.
module fractal_spiral_oscillator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // [24:0] out_x, [49:25] out_y, [74:50] out_z
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  fso_pkg::cmd_t    cmd;
  fso_pkg::status_t stat;
  logic [24:0]      res_x, res_y, res_z;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {5'd0, res_z, res_y, res_x};

  fso_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_tick   (s_tdata[0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fso_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_z     (res_z)
  );

  // a tick transfer starts work, so no second item is taken right after it
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[0]) |=> !s_tready)
    else $error("input taken while a sample is in work");

  // octave count seen by the sequencer is always clamped
  a_n_clamped: assert property (@(posedge clk) disable iff (rst)
    (stat.n_oct != 5'd0) && (stat.n_oct <= 5'(fso_pkg::MAX_OCTAVES)))
    else $error("octave count out of range");

  // envelope is never negative, so z stays at or above minus one
  a_z_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[74:50]) >= -25'sd65536))
    else $error("out_z below envelope floor");

endmodule
